@@ hw/rtl/varint_pkg.sv @@
package varint_pkg;

  // Action codes on the input channel
  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ENC_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DEC_VALUE = 2'd1;
  localparam logic [1:0] KIND_OVERLONG  = 2'd2;

  // Byte layout
  localparam logic [7:0] SEG_MASK  = 8'h7F;
  localparam logic [7:0] CONT_MASK = 8'h80;
  localparam int unsigned SEG_BITS = 7;

  // Overlong limits for the shift position
  localparam logic [6:0] LIMIT_SHORT = 7'd32;
  localparam logic [6:0] LIMIT_LONG  = 7'd64;

  // Commands from controller to datapath
  typedef struct packed {
    logic enc_load;   // load a new encode value and emit its first byte
    logic enc_step;   // emit the next byte of the running encode
    logic dec_step;   // fold one input byte into the decoder
  } vc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic first_more; // encode value needs more than one byte
    logic rest_more;  // running encode needs more bytes after this one
    logic dec_emit;   // decode byte ends a value or raises an overlong error
  } vc_status_t;

endpackage

@@ hw/rtl/varint_codec.sv @@
// LEB128-style VarInt/VarLong codec, 7 data bits per byte, bit 7 continues.
// Input channel (in_valid/in_ready): in_action selects encode of in_value or
// decode of in_byte; in_long_form picks 64-bit form (latched on the first
// decode byte of a sequence).
// Result channel (out_valid/out_ready): out_kind tells an encoded byte, a
// decoded value with out_byte_count, or an overlong error; out_last marks
// the final beat caused by an input item.
// Latency: the first result beat is valid the cycle after the input beat.
// Decode takes a new input byte whenever the output slot is free; an encode
// item emits one byte per result beat (1-5 short, 1-10 long) through the
// single output register that the encoder feeds one byte at a time. The
// input stays blocked until the last encoded byte is loaded.
// Continuation bytes give no result beat unless they make the value overlong.
// Reset clears the decoder accumulator, shift, byte count and width, and
// empties the output register.
// A stalled receiver holds the current result beat and blocks new input
// until it is taken; an input beat is taken in the same cycle that the
// waiting result is drained.
module varint_codec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic               in_long_form,
  input  logic signed [63:0] in_value,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_byte,
  output logic signed [63:0] out_decoded_value,
  output logic [3:0]         out_byte_count,
  output logic               out_last
);

  varint_pkg::vc_cmd_t    cmd;
  varint_pkg::vc_status_t status;

  varint_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  varint_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_long_form      (in_long_form),
    .in_value          (in_value),
    .in_byte           (in_byte),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_decoded_value (out_decoded_value),
    .out_byte_count    (out_byte_count),
    .out_last          (out_last)
  );

endmodule

@@ hw/rtl/varint_ctrl.sv @@
module varint_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  varint_pkg::vc_status_t status,
  output varint_pkg::vc_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ENC  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  logic accept;
  logic out_load;

  // Output slot frees up when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Sequence commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == varint_pkg::ACT_ENCODE) begin
            cmd.enc_load = 1'b1;
            out_load     = 1'b1;
            if (status.first_more) begin
              state_nxt = ST_ENC;
            end
          end else begin
            cmd.dec_step = 1'b1;
            out_load     = status.dec_emit;
          end
        end
      end
      ST_ENC: begin
        if (slot_free) begin
          cmd.enc_step = 1'b1;
          out_load     = 1'b1;
          if (!status.rest_more) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/varint_dp.sv @@
module varint_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  varint_pkg::vc_cmd_t    cmd,
  output varint_pkg::vc_status_t status,
  input  logic                  in_long_form,
  input  logic signed [63:0]    in_value,
  input  logic [7:0]            in_byte,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_byte,
  output logic signed [63:0]    out_decoded_value,
  output logic [3:0]            out_byte_count,
  output logic                  out_last
);

  // Encoder shift register
  logic [63:0] enc_v_r, enc_v_nxt;
  logic [63:0] enc_first;

  // Decoder state
  logic [63:0] acc_r, acc_nxt;
  logic [6:0]  shift_r, shift_nxt;
  logic [3:0]  seen_r, seen_nxt;
  logic        wide_r, wide_nxt;

  // Result payload
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [63:0] val_r, val_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;

  // Decode step terms
  logic        dec_wide;
  logic [63:0] acc_upd;
  logic [6:0]  shift_upd;
  logic [3:0]  seen_upd;
  logic        dec_cont;
  logic        overlong;
  logic [63:0] dec_val;

  // Mask the encode value to 32 bits in short form
  assign enc_first = in_long_form ? in_value : {32'd0, in_value[31:0]};

  assign status.first_more = |enc_first[63:varint_pkg::SEG_BITS];
  assign status.rest_more  = |enc_v_r[63:varint_pkg::SEG_BITS];

  // Latch the width on the first byte of a sequence
  assign dec_wide  = (seen_r == 4'd0) ? in_long_form : wide_r;
  assign acc_upd   = acc_r | ({56'd0, in_byte & varint_pkg::SEG_MASK} << shift_r);
  assign seen_upd  = seen_r + 4'd1;
  assign shift_upd = shift_r + 7'(varint_pkg::SEG_BITS);
  assign dec_cont  = |(in_byte & varint_pkg::CONT_MASK);
  assign overlong  = shift_upd >= (dec_wide ? varint_pkg::LIMIT_LONG
                                            : varint_pkg::LIMIT_SHORT);
  assign dec_val   = dec_wide ? acc_upd : {{32{acc_upd[31]}}, acc_upd[31:0]};

  assign status.dec_emit = !dec_cont || overlong;

  always_comb begin
    enc_v_nxt = enc_v_r;
    acc_nxt   = acc_r;
    shift_nxt = shift_r;
    seen_nxt  = seen_r;
    wide_nxt  = wide_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;

    // Emit the first encoded byte and keep the rest
    if (cmd.enc_load) begin
      enc_v_nxt = enc_first >> varint_pkg::SEG_BITS;
      kind_nxt  = varint_pkg::KIND_ENC_BYTE;
      byte_nxt  = {status.first_more, enc_first[6:0]};
      val_nxt   = '0;
      cnt_nxt   = '0;
      last_nxt  = !status.first_more;
    end

    // Advance the running encode by one byte
    if (cmd.enc_step) begin
      enc_v_nxt = enc_v_r >> varint_pkg::SEG_BITS;
      kind_nxt  = varint_pkg::KIND_ENC_BYTE;
      byte_nxt  = {status.rest_more, enc_v_r[6:0]};
      val_nxt   = '0;
      cnt_nxt   = '0;
      last_nxt  = !status.rest_more;
    end

    // Fold one byte into the decoder
    if (cmd.dec_step) begin
      if (!dec_cont) begin
        kind_nxt  = varint_pkg::KIND_DEC_VALUE;
        byte_nxt  = '0;
        val_nxt   = dec_val;
        cnt_nxt   = seen_upd;
        last_nxt  = 1'b1;
        acc_nxt   = '0;
        shift_nxt = '0;
        seen_nxt  = '0;
        wide_nxt  = 1'b0;
      end else if (overlong) begin
        kind_nxt  = varint_pkg::KIND_OVERLONG;
        byte_nxt  = '0;
        val_nxt   = '0;
        cnt_nxt   = '0;
        last_nxt  = 1'b1;
        acc_nxt   = '0;
        shift_nxt = '0;
        seen_nxt  = '0;
        wide_nxt  = 1'b0;
      end else begin
        acc_nxt   = acc_upd;
        shift_nxt = shift_upd;
        seen_nxt  = seen_upd;
        wide_nxt  = dec_wide;
      end
    end
  end

  // Decoder state clears at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      shift_r <= '0;
      seen_r  <= '0;
      wide_r  <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      seen_r  <= seen_nxt;
      wide_r  <= wide_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    enc_v_r <= enc_v_nxt;
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    val_r   <= val_nxt;
    cnt_r   <= cnt_nxt;
    last_r  <= last_nxt;
  end

  assign out_kind          = kind_r;
  assign out_byte          = byte_r;
  assign out_decoded_value = val_r;
  assign out_byte_count    = cnt_r;
  assign out_last          = last_r;

endmodule
